[sv/graph_m_coloring_check_macros.svh]
// Assertion macros shared by the checker of the graph coloring block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef GRAPH_M_COLORING_CHECK_MACROS_SVH
`define GRAPH_M_COLORING_CHECK_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GMC_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GMC_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

[sv/gmc_pkg.sv]
// Package of the graph coloring block: field widths, codes and the
// controller to datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gmc_pkg;

  localparam int IDX_W   = 4;
  localparam int ROW_W   = 16;
  localparam int CFG_W   = 5;
  localparam int COLOR_W = 5;
  localparam int TRY_W   = 6;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_COLOR_COUNT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic concluded;
    logic found;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

[sv/graph_m_coloring_check.sv]
// Top level of the graph coloring block: joins the controller and the
// datapath. Uses gmc_pkg, gmc_ctrl and gmc_dp.
//
//   Port group   Direction  Beat contents
//   in_          in         action, row_index, row_bits
//   out_         out        colorable
//   cfg_         in         register index and write data
//
// A row load is written when its beat is accepted. A solve has a start step,
// a search step for every color trial or backtrack, and a finish step: the
// search checks one node and one color per cycle against all lower nodes.
// Reset is synchronous and clears the controller, the counts and the output valid flag.
// Input beats stall while a search runs; a held result does not block loads.
`timescale 1ns / 1ps
`default_nettype none

module graph_m_coloring_check #(
  parameter int MAX_NODES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [gmc_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_action,
  input  wire logic [gmc_pkg::IDX_W-1:0] in_row_index,
  input  wire logic [gmc_pkg::ROW_W-1:0] in_row_bits,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_colorable
);

  gmc_pkg::cmd_t cmd;
  gmc_pkg::sts_t sts;

  gmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  gmc_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_row_index  (in_row_index),
    .in_row_bits   (in_row_bits),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_colorable (out_colorable)
  );

endmodule

`default_nettype wire

[sv/gmc_dp.sv]
// Datapath of the graph coloring block: configuration, adjacency rows,
// node colors, search position and the result register. Uses gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmc_dp #(
  parameter int MAX_NODES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [gmc_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic [gmc_pkg::IDX_W-1:0] in_row_index,
  input  wire logic [gmc_pkg::ROW_W-1:0] in_row_bits,
  input  wire logic                      out_stall,
  input  wire gmc_pkg::cmd_t             cmd,
  output gmc_pkg::sts_t                  sts,
  output logic                           out_valid,
  output logic                           out_colorable
);

  localparam int NODES = (MAX_NODES < 31) ? MAX_NODES : 31;
  localparam int ROWS  = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int NIW   = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);
  localparam int RIW   = $clog2(ROWS);

  logic [gmc_pkg::CFG_W-1:0]   node_count_r;
  logic [gmc_pkg::CFG_W-1:0]   color_count_r;
  logic [gmc_pkg::ROW_W-1:0]   adj_mem [ROWS];
  logic [gmc_pkg::COLOR_W-1:0] color_r [NODES];
  logic [NODES-1:0]            raised_r;
  logic [CNT_W-1:0]            n_r;
  logic [gmc_pkg::COLOR_W-1:0] m_r;
  logic [CNT_W-1:0]            node_r;
  logic [gmc_pkg::TRY_W-1:0]   try_r;
  logic [gmc_pkg::COLOR_W-1:0] maxc_r;
  logic                        out_valid_r;
  logic                        colorable_r;

  logic [CNT_W-1:0]            n_start;
  logic [gmc_pkg::COLOR_W-1:0] m_start;
  logic [CNT_W-1:0]            node_dec;
  logic [NIW-1:0]              node_idx;
  logic [NIW-1:0]              prev_idx;
  logic [4:0]                  node5;
  logic [3:0]                  col;
  logic                        col_ok;
  logic [gmc_pkg::TRY_W-1:0]   inc;
  logic [gmc_pkg::TRY_W-1:0]   lim;
  logic                        over;
  logic                        conflict;
  logic                        found;

  always_comb begin
    if (int'(node_count_r) > NODES) begin
      n_start = CNT_W'(NODES);
    end else begin
      n_start = CNT_W'(node_count_r);
    end
    if (color_count_r > gmc_pkg::COLOR_W'(n_start)) begin
      m_start = gmc_pkg::COLOR_W'(n_start);
    end else begin
      m_start = color_count_r;
    end
  end

  assign node_dec = node_r - CNT_W'(1);
  assign node_idx = node_r[NIW-1:0];
  assign prev_idx = node_dec[NIW-1:0];
  assign node5    = 5'(node_r);
  assign col_ok   = !node5[4];
  assign col      = node5[3:0];
  assign inc      = {1'b0, maxc_r} + gmc_pkg::TRY_W'(1);
  assign lim      = (inc < {1'b0, m_r}) ? inc : {1'b0, m_r};
  assign over     = try_r > lim;
  assign found    = node_r == n_r;

  // A trial color clashes when a lower node with an edge into this node holds it.
  // Nodes at and above the current one hold color zero, which never matches.
  always_comb begin
    conflict = 1'b0;
    for (int k = 0; k < ROWS; k++) begin
      if (col_ok && adj_mem[k][col] && ({1'b0, color_r[k]} == try_r)) begin
        conflict = 1'b1;
      end
    end
  end

  assign sts.found     = found;
  assign sts.concluded = found || (over && (node_r == '0));
  assign sts.out_full  = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= '0;
      color_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmc_pkg::CFG_NODE_COUNT:  node_count_r  <= cfg_wdata;
        gmc_pkg::CFG_COLOR_COUNT: color_count_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (5'(in_row_index) < 5'(ROWS))) begin
      adj_mem[in_row_index[RIW-1:0]] <= in_row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int k = 0; k < NODES; k++) begin
        color_r[k] <= '0;
      end
      raised_r <= '0;
      n_r      <= n_start;
      m_r      <= m_start;
      node_r   <= '0;
      try_r    <= gmc_pkg::TRY_W'(1);
      maxc_r   <= '0;
    end else if (cmd.step) begin
      if (over) begin
        node_r             <= node_dec;
        try_r              <= {1'b0, color_r[prev_idx]} + gmc_pkg::TRY_W'(1);
        color_r[prev_idx]  <= '0;
        raised_r[prev_idx] <= 1'b0;
        if (raised_r[prev_idx]) begin
          maxc_r <= maxc_r - gmc_pkg::COLOR_W'(1);
        end
      end else if (conflict) begin
        try_r <= try_r + gmc_pkg::TRY_W'(1);
      end else begin
        color_r[node_idx]  <= try_r[gmc_pkg::COLOR_W-1:0];
        raised_r[node_idx] <= try_r[gmc_pkg::COLOR_W-1:0] > maxc_r;
        if (try_r[gmc_pkg::COLOR_W-1:0] > maxc_r) begin
          maxc_r <= try_r[gmc_pkg::COLOR_W-1:0];
        end
        node_r <= node_r + CNT_W'(1);
        try_r  <= gmc_pkg::TRY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      colorable_r <= found;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_colorable = colorable_r;

endmodule

`default_nettype wire

[sv/gmc_ctrl.sv]
// Controller of the graph coloring block: accepts beats, starts and steps
// the search and hands the answer to the output register. Uses gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_action,
  input  wire logic          out_stall,
  input  wire gmc_pkg::sts_t sts,
  output gmc_pkg::cmd_t      cmd,
  output logic               in_stall
);

  gmc_pkg::state_t state_r;
  gmc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      gmc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == gmc_pkg::ACT_SOLVE) begin
            cmd.start = 1'b1;
            state_nxt = gmc_pkg::ST_SEARCH;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      gmc_pkg::ST_SEARCH: begin
        if (sts.concluded) begin
          if (!sts.out_full || !out_stall) begin
            cmd.finish = 1'b1;
            state_nxt  = gmc_pkg::ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/gmc_checker.sv]
// Port-level checker of the graph coloring block and its bind.
// Uses graph_m_coloring_check_macros.svh and gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "graph_m_coloring_check_macros.svh"

module gmc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_action,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_colorable
);

  logic solve_act;

  assign solve_act = (in_action == gmc_pkg::ACT_SOLVE);

  `GMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_colorable), "result beat changed while stalled")
  `GMC_ASSERT_SAME(a_busy_after_solve, $rose(in_stall),
                   $past(in_valid && solve_act), "input stalled without a solve beat")
  `GMC_ASSERT_NEXT(a_load_no_stall, in_valid && !in_stall && !solve_act,
                   !in_stall, "row load stalled the input")
  `GMC_ASSERT_SAME(a_result_ends_search, $rose(out_valid),
                   $fell(in_stall), "result appeared outside the end of a search")

endmodule

bind graph_m_coloring_check gmc_checker u_gmc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_colorable (out_colorable)
);

`default_nettype wire

[sim/testbench.sv]
// Testbench for graph_m_coloring_check: a directed table, then random phases of row
// loads and solves, checked beat by beat against a backtracking search of its own.
// Depends on gmc_pkg and the graph_m_coloring_check RTL; reads no files.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_NODES   = 16;
  localparam int RANDOM_BEATS = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    DK_NODES,
    DK_COLORS,
    DK_LOAD,
    DK_SOLVE
  } dir_kind_t;

  typedef struct packed {
    dir_kind_t   kind;
    logic [4:0]  reg_value;
    logic [3:0]  row_idx;
    logic [15:0] row_val;
    logic        has_ans;
    logic        fixed_ans;
  } dir_step_t;

  typedef enum {
    PROF_SMALL,
    PROF_EASY,
    PROF_PATH
  } profile_t;

  localparam int NUM_DIRECTED = 33;
  localparam dir_step_t DIRECTED_STEPS [0:NUM_DIRECTED-1] = '{
    '{DK_SOLVE,  5'd0,  4'd0,  16'h0000, 1'b1, 1'b1},
    '{DK_NODES,  5'd2,  4'd0,  16'h0000, 1'b0, 1'b0},
    '{DK_COLORS, 5'd1,  4'd0,  16'h0000, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd0,  16'h0001, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd1,  16'h0003, 1'b0, 1'b0},
    '{DK_SOLVE,  5'd0,  4'd0,  16'h0000, 1'b1, 1'b1},
    '{DK_LOAD,   5'd0,  4'd0,  16'hFFFF, 1'b0, 1'b0},
    '{DK_SOLVE,  5'd0,  4'd0,  16'h0000, 1'b1, 1'b0},
    '{DK_COLORS, 5'd0,  4'd0,  16'h0000, 1'b0, 1'b0},
    '{DK_SOLVE,  5'd0,  4'd0,  16'h0000, 1'b1, 1'b0},
    '{DK_NODES,  5'd31, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{DK_COLORS, 5'd31, 4'd0,  16'h0000, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd0,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd1,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd2,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd3,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd4,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd5,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd6,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd7,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd8,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd9,  16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd10, 16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd11, 16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd12, 16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd13, 16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd14, 16'hFFFF, 1'b0, 1'b0},
    '{DK_LOAD,   5'd0,  4'd15, 16'hFFFF, 1'b0, 1'b0},
    '{DK_SOLVE,  5'd0,  4'd0,  16'h0000, 1'b1, 1'b1},
    '{DK_COLORS, 5'd1,  4'd0,  16'h0000, 1'b0, 1'b0},
    '{DK_SOLVE,  5'd0,  4'd0,  16'h0000, 1'b1, 1'b0},
    '{DK_COLORS, 5'd2,  4'd0,  16'h0000, 1'b0, 1'b0},
    '{DK_SOLVE,  5'd0,  4'd0,  16'h0000, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = gmc_pkg::CFG_NODE_COUNT;
  logic [gmc_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = gmc_pkg::ACT_LOAD;
  logic [gmc_pkg::IDX_W-1:0] in_row_index = '0;
  logic [gmc_pkg::ROW_W-1:0] in_row_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_colorable;

  logic [15:0] row_store [0:MAX_NODES-1];
  logic [4:0] node_count_q = '0;
  logic [4:0] color_count_q = '0;
  logic pending_colorable [$];
  int mismatch_count = 0;
  int burst_left = 0;
  bit hold_off_req = 1'b0;

  graph_m_coloring_check #(
    .MAX_NODES(MAX_NODES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_row_index(in_row_index),
    .in_row_bits(in_row_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_colorable(out_colorable)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Depth-first search over nodes in index order. A node never takes a color
  // more than one above the largest color used below it, since colors are
  // interchangeable; only edges from a lower node into the node matter.
  function automatic logic predict_colorable();
    int n;
    int m;
    int node;
    int c;
    int top;
    int lim;
    int k;
    int hue [0:MAX_NODES-1];
    logic found;
    n = (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
    m = (color_count_q > n) ? n : color_count_q;
    for (k = 0; k < MAX_NODES; k++) hue[k] = 0;
    node = 0;
    while (node >= 0 && node < n) begin
      top = 0;
      for (k = 0; k < node; k++) if (hue[k] > top) top = hue[k];
      lim = (top + 1 < m) ? top + 1 : m;
      found = 1'b0;
      for (c = hue[node] + 1; c <= lim && !found; c++) begin
        found = 1'b1;
        for (k = 0; k < node; k++) begin
          if (row_store[k][node] && hue[k] == c) found = 1'b0;
        end
        if (found) hue[node] = c;
      end
      if (found) begin
        node++;
      end else begin
        hue[node] = 0;
        node--;
      end
    end
    return (node == n);
  endfunction

  function automatic logic [15:0] row_for(profile_t prof, int idx);
    logic [31:0] r;
    logic [31:0] t;
    r = $urandom;
    case (prof)
      PROF_PATH: begin
        t = (32'd2 << idx) | (r & ((32'd2 << idx) - 32'd1));
        return t[15:0];
      end
      PROF_SMALL: begin
        case ($urandom_range(0, 2))
          0: return r[15:0] & r[31:16];
          1: return r[15:0];
          default: return r[15:0] | r[31:16];
        endcase
      end
      default: return r[15:0];
    endcase
  endfunction

  task automatic send_beat(logic act, logic [3:0] idx, logic [15:0] bits,
                           logic has_ans, logic fixed_ans);
    int gap;
    logic ans;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_row_index <= idx;
    in_row_bits <= bits;
    do @(posedge clk); while (in_stall);
    if (act == gmc_pkg::ACT_LOAD) begin
      row_store[idx] = bits;
    end else begin
      ans = has_ans ? fixed_ans : predict_colorable();
      pending_colorable = {pending_colorable, ans};
    end
  endtask

  task automatic send_solve();
    logic [31:0] r;
    r = $urandom;
    send_beat(gmc_pkg::ACT_SOLVE, r[3:0], r[31:16], 1'b0, 1'b0);
  endtask

  // Registers change only once every result is out and the block has settled.
  task automatic set_register(logic idx, logic [4:0] value);
    in_valid <= 1'b0;
    while (pending_colorable.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gmc_pkg::CFG_NODE_COUNT) node_count_q = value;
    else color_count_q = value;
  endtask

  initial begin : result_check
    logic want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_colorable.size() == 0) begin
          report_mismatch("result beat with no solve outstanding");
        end else begin
          want = pending_colorable.pop_front();
          if (out_colorable !== want)
            report_mismatch($sformatf("colorable got %b expected %b", out_colorable, want));
        end
      end
    end
  end

  initial begin : receiver
    int seg_left;
    int stall_pct;
    seg_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    dir_step_t st;
    profile_t prof;
    int random_beats;
    int phase_no;
    int n_cfg;
    int m_cfg;
    int n_eff;
    int body;
    int pick;
    int i;
    int idx;
    for (i = 0; i < MAX_NODES; i++) row_store[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) begin
      st = DIRECTED_STEPS[i];
      case (st.kind)
        DK_NODES: set_register(gmc_pkg::CFG_NODE_COUNT, st.reg_value);
        DK_COLORS: set_register(gmc_pkg::CFG_COLOR_COUNT, st.reg_value);
        DK_LOAD: send_beat(gmc_pkg::ACT_LOAD, st.row_idx, st.row_val, 1'b0, 1'b0);
        default: send_beat(gmc_pkg::ACT_SOLVE, st.row_idx, st.row_val,
                           st.has_ans, st.fixed_ans);
      endcase
    end

    random_beats = 0;
    phase_no = 0;
    while (random_beats < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7 || phase_no == 3) begin
        prof = PROF_SMALL;
        n_cfg = $urandom_range(0, 6);
        m_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 31) : $urandom_range(0, 4);
      end else if (pick < 9) begin
        prof = PROF_EASY;
        n_cfg = $urandom_range(7, 31);
        m_cfg = $urandom_range(16, 31);
      end else begin
        prof = PROF_PATH;
        n_cfg = $urandom_range(7, 31);
        m_cfg = 2;
      end
      set_register(gmc_pkg::CFG_NODE_COUNT, n_cfg[4:0]);
      set_register(gmc_pkg::CFG_COLOR_COUNT, m_cfg[4:0]);
      n_eff = (n_cfg > MAX_NODES) ? MAX_NODES : n_cfg;

      for (idx = 0; idx < n_eff; idx++) begin
        send_beat(gmc_pkg::ACT_LOAD, idx[3:0], row_for(prof, idx), 1'b0, 1'b0);
        random_beats++;
      end

      // The receiver holds off while solves keep coming, so the held result
      // backs up into the input channel.
      if (phase_no == 3) begin
        hold_off_req = 1'b1;
        repeat (8) begin
          send_solve();
          random_beats++;
        end
      end

      body = $urandom_range(10, 40);
      repeat (body) begin
        if ($urandom_range(0, 99) < 35) begin
          send_solve();
        end else begin
          idx = $urandom_range(0, MAX_NODES - 1);
          send_beat(gmc_pkg::ACT_LOAD, idx[3:0],
                    (idx < n_eff) ? row_for(prof, idx) : 16'($urandom), 1'b0, 1'b0);
        end
        random_beats++;
      end
      phase_no++;
    end

    in_valid <= 1'b0;
    while (pending_colorable.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[graph_m_coloring_check.f]
+incdir+sv
sv/gmc_pkg.sv
sv/gmc_dp.sv
sv/gmc_ctrl.sv
sv/graph_m_coloring_check.sv
sv/gmc_checker.sv
sim/testbench.sv
